/* sv/mfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_pkg: shared types and constants of the feedback queue dispatcher
// Codes, controller state and the command/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mfd_pkg;

	localparam int MAX_CPUS_DEF     = 8;
	localparam int QUEUE_DEPTH_DEF  = 64;
	localparam int TASK_ID_BITS_DEF = 8;
	localparam int LEVELS           = 4;
	localparam int MAX_RESULTS      = 8;

	localparam logic [3:0] CPU_COUNT_RESET    = 4'd1;
	localparam logic [7:0] BOOST_PERIOD_RESET = 8'd3;

	localparam logic [0:0] REG_CPU_COUNT    = 1'b0;
	localparam logic [0:0] REG_BOOST_PERIOD = 1'b1;

	localparam logic [1:0] FUNC_SUBMIT = 2'd0;
	localparam logic [1:0] FUNC_FINISH = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_DISP = 2'd1;
	localparam logic [1:0] KIND_IDLE = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NOT_RUN  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUB,
		S_FIN,
		S_BUMP,
		S_BOOST_CHK,
		S_BOOST_WR,
		S_PEND_CHK,
		S_PEND_WR,
		S_REQ,
		S_DISP_CHK,
		S_DISP_EM,
		S_IDLE_EM
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SUBMIT,
		OP_FINISH,
		OP_BUMP,
		OP_LQ_POP,
		OP_BOOST_PUSH,
		OP_PEND_RD,
		OP_PEND_PUSH,
		OP_PEND_CLR,
		OP_REQUEUE,
		OP_IDLE_EMIT,
		OP_DISP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] lv;
		logic       idx_clr;
		logic       idx_inc;
	} cmd_t;

	typedef struct packed {
		logic       out_free;
		logic       boost;
		logic       pend_end;
		logic       slot_end;
		logic       disp_end;
		logic [3:0] cnt_nz;
	} st_t;

endpackage
`default_nettype wire

/* sv/mfd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_ctrl: dispatcher sequencer
// Walks submit, finish and the tick steps, issuing one command per cycle while no stalled result holds it.
// ----------------------------------------------------------------------------
module mfd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    func,
	input  wire mfd_pkg::st_t  st,
	output mfd_pkg::cmd_t      cmd
);

	mfd_pkg::state_t state_q, state_nx;
	logic [1:0] blv_q, blv_nx;
	logic [1:0] low_lv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfd_pkg::S_IDLE;
			blv_q   <= 2'd3;
		end else begin
			state_q <= state_nx;
			blv_q   <= blv_nx;
		end
	end

	// lowest nonempty level
	always_comb begin
		low_lv = 2'd3;
		if (st.cnt_nz[2]) low_lv = 2'd2;
		if (st.cnt_nz[1]) low_lv = 2'd1;
		if (st.cnt_nz[0]) low_lv = 2'd0;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			mfd_pkg::S_IDLE: begin
				if (in_valid) begin
					case (func)
						mfd_pkg::FUNC_SUBMIT: state_nx = mfd_pkg::S_SUB;
						mfd_pkg::FUNC_FINISH: state_nx = mfd_pkg::S_FIN;
						mfd_pkg::FUNC_TICK:   state_nx = mfd_pkg::S_BUMP;
						default:              state_nx = mfd_pkg::S_IDLE;
					endcase
				end
			end
			mfd_pkg::S_SUB, mfd_pkg::S_FIN, mfd_pkg::S_IDLE_EM: begin
				if (st.out_free) state_nx = mfd_pkg::S_IDLE;
			end
			mfd_pkg::S_BUMP: state_nx = mfd_pkg::S_BOOST_CHK;
			mfd_pkg::S_BOOST_CHK: begin
				if (!st.boost || blv_q == 2'd0) state_nx = mfd_pkg::S_PEND_CHK;
				else if (st.cnt_nz[blv_q]) state_nx = mfd_pkg::S_BOOST_WR;
			end
			mfd_pkg::S_BOOST_WR: state_nx = mfd_pkg::S_BOOST_CHK;
			mfd_pkg::S_PEND_CHK: begin
				if (st.pend_end) state_nx = mfd_pkg::S_REQ;
				else state_nx = mfd_pkg::S_PEND_WR;
			end
			mfd_pkg::S_PEND_WR: state_nx = mfd_pkg::S_PEND_CHK;
			mfd_pkg::S_REQ: begin
				if (st.slot_end) state_nx = mfd_pkg::S_DISP_CHK;
			end
			mfd_pkg::S_DISP_CHK: begin
				if (st.cnt_nz == 4'd0) state_nx = mfd_pkg::S_IDLE_EM;
				else state_nx = mfd_pkg::S_DISP_EM;
			end
			mfd_pkg::S_DISP_EM: begin
				if (st.out_free) begin
					if (st.disp_end) state_nx = mfd_pkg::S_IDLE;
					else state_nx = mfd_pkg::S_DISP_CHK;
				end
			end
			default: state_nx = mfd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '{op: mfd_pkg::OP_NONE, lv: 2'd0, idx_clr: 1'b0, idx_inc: 1'b0};
		in_stall    = 1'b1;
		blv_nx      = blv_q;
		case (state_q)
			mfd_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd.op = mfd_pkg::OP_LOAD;
			end
			mfd_pkg::S_SUB: begin
				if (st.out_free) cmd.op = mfd_pkg::OP_SUBMIT;
			end
			mfd_pkg::S_FIN: begin
				if (st.out_free) cmd.op = mfd_pkg::OP_FINISH;
			end
			mfd_pkg::S_IDLE_EM: begin
				if (st.out_free) cmd.op = mfd_pkg::OP_IDLE_EMIT;
			end
			mfd_pkg::S_BUMP: begin
				cmd.op = mfd_pkg::OP_BUMP;
				blv_nx = 2'd3;
			end
			mfd_pkg::S_BOOST_CHK: begin
				if (!st.boost || blv_q == 2'd0) begin
					cmd.idx_clr = 1'b1;
				end else if (st.cnt_nz[blv_q]) begin
					cmd.op = mfd_pkg::OP_LQ_POP;
					cmd.lv = blv_q;
				end else begin
					blv_nx = blv_q - 2'd1;
				end
			end
			mfd_pkg::S_BOOST_WR: cmd.op = mfd_pkg::OP_BOOST_PUSH;
			mfd_pkg::S_PEND_CHK: begin
				if (st.pend_end) begin
					cmd.op      = mfd_pkg::OP_PEND_CLR;
					cmd.idx_clr = 1'b1;
				end else begin
					cmd.op = mfd_pkg::OP_PEND_RD;
				end
			end
			mfd_pkg::S_PEND_WR: begin
				cmd.op      = mfd_pkg::OP_PEND_PUSH;
				cmd.idx_inc = 1'b1;
			end
			mfd_pkg::S_REQ: begin
				cmd.op = mfd_pkg::OP_REQUEUE;
				if (st.slot_end) cmd.idx_clr = 1'b1;
				else cmd.idx_inc = 1'b1;
			end
			mfd_pkg::S_DISP_CHK: begin
				if (st.cnt_nz != 4'd0) begin
					cmd.op = mfd_pkg::OP_LQ_POP;
					cmd.lv = low_lv;
				end
			end
			mfd_pkg::S_DISP_EM: begin
				if (st.out_free) begin
					cmd.op = mfd_pkg::OP_DISP_EMIT;
					if (!st.disp_end) cmd.idx_inc = 1'b1;
				end
			end
			default: begin
				cmd.op = mfd_pkg::OP_NONE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == mfd_pkg::OP_LOAD) |-> (state_q == mfd_pkg::S_IDLE && !in_stall))
		else $error("input taken outside idle");
	a_boost_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfd_pkg::S_BOOST_WR) |-> st.boost)
		else $error("boost move without boost tick");
	a_disp_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfd_pkg::S_DISP_EM && $past(state_q) == mfd_pkg::S_DISP_CHK)
		|-> $past(cmd.op) == mfd_pkg::OP_LQ_POP)
		else $error("dispatch without a queue pop");
`endif

endmodule
`default_nettype wire

/* sv/mfd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_datapath: queues, running table and result register
// Level FIFOs and pending buffer in memories, slot table in flops.
// ----------------------------------------------------------------------------
module mfd_datapath #(
	parameter int MAX_CPUS     = mfd_pkg::MAX_CPUS_DEF,
	parameter int QUEUE_DEPTH  = mfd_pkg::QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = mfd_pkg::TASK_ID_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [0:0]    cfg_index,
	input  wire logic [7:0]    cfg_wdata,
	input  wire logic [7:0]    task_id,
	input  wire logic [3:0]    requested_priority,
	input  wire mfd_pkg::cmd_t cmd,
	output mfd_pkg::st_t       st,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [1:0]         kind,
	output logic [1:0]         status,
	output logic [2:0]         slot,
	output logic [7:0]         task_id_res,
	output logic [2:0]         level,
	output logic               last
);

	localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int IW        = (CW > 4) ? CW : 4;
	localparam int RUN_SLOTS = (MAX_CPUS < mfd_pkg::MAX_RESULTS) ? MAX_CPUS
	                                                              : mfd_pkg::MAX_RESULTS;
	localparam int SW        = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
	localparam int IDW       = TASK_ID_BITS;

	logic [3:0]     cpu_q;
	logic [7:0]     bper_q;
	logic [7:0]     ticks_q;
	logic [7:0]     ticks_nx;
	logic           boost_q;
	logic [CW-1:0]  live_q;
	logic [CW-1:0]  pend_cnt_q;
	logic [QW-1:0]  head_q [mfd_pkg::LEVELS];
	logic [CW-1:0]  cnt_q  [mfd_pkg::LEVELS];
	logic [IW-1:0]  idx_q;
	logic [IDW-1:0] id_q;
	logic [2:0]     prio_q;
	logic [1:0]     pop_lv_q;

	logic [IDW-1:0] lq_mem [mfd_pkg::LEVELS][QUEUE_DEPTH];
	logic [IDW-1:0] lq_rd_q;
	logic [IDW+1:0] pend_mem [QUEUE_DEPTH];
	logic [IDW+1:0] pend_rd_q;

	logic           run_v_q  [RUN_SLOTS];
	logic           run_d_q  [RUN_SLOTS];
	logic [IDW-1:0] run_id_q [RUN_SLOTS];
	logic [1:0]     run_lv_q [RUN_SLOTS];

	logic [15:0]    id_in16;
	logic [SW-1:0]  sidx;
	logic           push_en, pop_en;
	logic [1:0]     push_lv, pop_lv;
	logic [IDW-1:0] push_id;
	logic [CW:0]    pos_sum;
	logic [QW-1:0]  wr_pos;
	logic           full;
	logic           fin_hit;
	logic [SW-1:0]  fin_slot;
	logic [3:0]     lim;
	logic           all_zero;
	logic [3:0]     cnt_nz;
	logic           disp_end;
	logic           out_free;

	logic           em_en;
	logic [1:0]     em_kind, em_status;
	logic [2:0]     em_slot, em_level;
	logic [IDW-1:0] em_id;
	logic [15:0]    em_id16;
	logic           em_last;

	assign id_in16  = 16'(task_id);
	assign sidx     = idx_q[SW-1:0];
	assign out_free = !out_valid || !out_stall;
	assign full     = (live_q >= CW'(QUEUE_DEPTH)) || (pend_cnt_q >= CW'(QUEUE_DEPTH));
	assign ticks_nx = ticks_q + 8'd1;

	// slot limit: zero acts as one, clamp to the slot table
	always_comb begin
		lim = cpu_q;
		if (cpu_q == 4'd0) lim = 4'd1;
		else if (cpu_q > 4'(RUN_SLOTS)) lim = 4'(RUN_SLOTS);
	end

	always_comb begin
		all_zero = 1'b1;
		cnt_nz   = 4'd0;
		for (int l = 0; l < mfd_pkg::LEVELS; l++) begin
			cnt_nz[l] = (cnt_q[l] != '0);
			if (cnt_q[l] != '0) all_zero = 1'b0;
		end
	end

	assign disp_end    = ((({1'b0, idx_q}) + (IW+1)'(1)) >= (IW+1)'(lim)) || all_zero;
	assign st.cnt_nz   = cnt_nz;
	assign st.out_free = out_free;
	assign st.boost    = boost_q;
	assign st.pend_end = (idx_q == IW'(pend_cnt_q));
	assign st.slot_end = (idx_q == IW'(RUN_SLOTS - 1));
	assign st.disp_end = disp_end;

	// lowest running slot holding the finished id
	always_comb begin
		fin_hit  = 1'b0;
		fin_slot = '0;
		for (int s = RUN_SLOTS - 1; s >= 0; s--) begin
			if (run_v_q[s] && !run_d_q[s] && run_id_q[s] == id_q) begin
				fin_hit  = 1'b1;
				fin_slot = SW'(s);
			end
		end
	end

	// queue push source
	always_comb begin
		push_en = 1'b0;
		push_lv = 2'd0;
		push_id = lq_rd_q;
		case (cmd.op)
			mfd_pkg::OP_BOOST_PUSH: begin
				push_en = 1'b1;
			end
			mfd_pkg::OP_PEND_PUSH: begin
				push_en = 1'b1;
				push_lv = pend_rd_q[IDW+1:IDW];
				push_id = pend_rd_q[IDW-1:0];
			end
			mfd_pkg::OP_REQUEUE: begin
				push_en = run_v_q[sidx] && !run_d_q[sidx];
				push_id = run_id_q[sidx];
				if (boost_q) push_lv = 2'd0;
				else if (run_lv_q[sidx] == 2'd3) push_lv = 2'd3;
				else push_lv = run_lv_q[sidx] + 2'd1;
			end
			default: push_en = 1'b0;
		endcase
	end

	assign pop_en  = (cmd.op == mfd_pkg::OP_LQ_POP);
	assign pop_lv  = cmd.lv;
	assign pos_sum = (CW+1)'(head_q[push_lv]) + (CW+1)'(cnt_q[push_lv]);
	assign wr_pos  = (pos_sum >= (CW+1)'(QUEUE_DEPTH)) ?
	                 QW'(pos_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(pos_sum);

	always_ff @(posedge clk) begin
		if (push_en) lq_mem[push_lv][wr_pos] <= push_id;
		if (pop_en) lq_rd_q <= lq_mem[pop_lv][head_q[pop_lv]];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == mfd_pkg::OP_SUBMIT && !full)
			pend_mem[pend_cnt_q[QW-1:0]] <= {2'(prio_q - 3'd1), id_q};
		if (cmd.op == mfd_pkg::OP_PEND_RD) pend_rd_q <= pend_mem[idx_q[QW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < mfd_pkg::LEVELS; l++) begin
				head_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			for (int l = 0; l < mfd_pkg::LEVELS; l++) begin
				if (pop_en && pop_lv == 2'(l)) begin
					head_q[l] <= (head_q[l] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q[l] + QW'(1);
				end
				if (push_en && push_lv == 2'(l) && !(pop_en && pop_lv == 2'(l)))
					cnt_q[l] <= cnt_q[l] + CW'(1);
				else if (pop_en && pop_lv == 2'(l) && !(push_en && push_lv == 2'(l)))
					cnt_q[l] <= cnt_q[l] - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q      <= mfd_pkg::CPU_COUNT_RESET;
			bper_q     <= mfd_pkg::BOOST_PERIOD_RESET;
			ticks_q    <= 8'd0;
			boost_q    <= 1'b0;
			live_q     <= '0;
			pend_cnt_q <= '0;
			idx_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mfd_pkg::REG_CPU_COUNT:    cpu_q  <= cfg_wdata[3:0];
					mfd_pkg::REG_BOOST_PERIOD: bper_q <= cfg_wdata;
					default:                   cpu_q  <= cpu_q;
				endcase
			end
			if (cmd.op == mfd_pkg::OP_BUMP) begin
				boost_q <= (ticks_nx == bper_q);
				ticks_q <= (ticks_nx == bper_q) ? 8'd0 : ticks_nx;
			end
			if (cmd.op == mfd_pkg::OP_SUBMIT && !full) begin
				live_q     <= live_q + CW'(1);
				pend_cnt_q <= pend_cnt_q + CW'(1);
			end
			if (cmd.op == mfd_pkg::OP_FINISH && fin_hit && live_q != '0)
				live_q <= live_q - CW'(1);
			if (cmd.op == mfd_pkg::OP_PEND_CLR) pend_cnt_q <= '0;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + IW'(1);
		end
	end

	// latched input and pop level
	always_ff @(posedge clk) begin
		if (cmd.op == mfd_pkg::OP_LOAD) begin
			id_q <= id_in16[IDW-1:0];
			if (requested_priority >= 4'd1 && requested_priority <= 4'd4)
				prio_q <= requested_priority[2:0];
			else
				prio_q <= 3'd1;
		end
		if (pop_en) pop_lv_q <= pop_lv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < RUN_SLOTS; s++) begin
				run_v_q[s] <= 1'b0;
				run_d_q[s] <= 1'b0;
			end
		end else begin
			if (cmd.op == mfd_pkg::OP_FINISH && fin_hit) run_d_q[fin_slot] <= 1'b1;
			if (cmd.op == mfd_pkg::OP_REQUEUE) begin
				run_v_q[sidx] <= 1'b0;
				run_d_q[sidx] <= 1'b0;
			end
			if (cmd.op == mfd_pkg::OP_DISP_EMIT) begin
				run_v_q[sidx] <= 1'b1;
				run_d_q[sidx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == mfd_pkg::OP_DISP_EMIT) begin
			run_id_q[sidx] <= lq_rd_q;
			run_lv_q[sidx] <= pop_lv_q;
		end
	end

	// result selection
	always_comb begin
		em_en     = 1'b0;
		em_kind   = mfd_pkg::KIND_ACK;
		em_status = mfd_pkg::STAT_OK;
		em_slot   = 3'd0;
		em_id     = id_q;
		em_level  = 3'd0;
		em_last   = 1'b1;
		case (cmd.op)
			mfd_pkg::OP_SUBMIT: begin
				em_en     = 1'b1;
				em_status = full ? mfd_pkg::STAT_FULL : mfd_pkg::STAT_OK;
				em_level  = prio_q;
			end
			mfd_pkg::OP_FINISH: begin
				em_en     = 1'b1;
				em_status = fin_hit ? mfd_pkg::STAT_OK : mfd_pkg::STAT_NOT_RUN;
			end
			mfd_pkg::OP_IDLE_EMIT: begin
				em_en   = 1'b1;
				em_kind = mfd_pkg::KIND_IDLE;
				em_id   = '0;
			end
			mfd_pkg::OP_DISP_EMIT: begin
				em_en    = 1'b1;
				em_kind  = mfd_pkg::KIND_DISP;
				em_slot  = idx_q[2:0];
				em_id    = lq_rd_q;
				em_level = {1'b0, pop_lv_q} + 3'd1;
				em_last  = disp_end;
			end
			default: em_en = 1'b0;
		endcase
	end

	assign em_id16 = 16'(em_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (em_en) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em_en) begin
			kind        <= em_kind;
			status      <= em_status;
			slot        <= em_slot;
			task_id_res <= em_id16[7:0];
			level       <= em_level;
			last        <= em_last;
		end
	end

`ifndef SYNTHESIS
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> (cnt_q[push_lv] < CW'(QUEUE_DEPTH)))
		else $error("push into a full level");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |-> (cnt_q[pop_lv] != '0))
		else $error("pop from an empty level");
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		em_en |-> out_free)
		else $error("result overwrites an untaken result");
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(QUEUE_DEPTH))
		else $error("live task count above store size");
`endif

endmodule
`default_nettype wire

/* sv/multilevel_feedback_dispatcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_feedback_dispatcher: four-level feedback queue dispatcher
// Buffers submitted tasks, marks finished ones and on each tick requeues and
// dispatches tasks to processor slots, boosting on a boost tick.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   input   | in        | in_valid/in_stall  | func, task_id, requested_priority
//   result  | out       | out_valid/out_stall| kind, status, slot, task_id_res,
//           |           |                    | level, last
//   config  | in        | cfg_we             | cfg_index, cfg_wdata
//
// Submit and finish take the transfer, then load the result register. A tick
// bumps the tick counter, on a boost tick moves levels 2 to 4 into level 1,
// pushes the pending tasks, requeues the slot table (eight slots by default)
// and dispatches or emits an idle result; each move through the single-port
// level memory is a registered read and a write.
// Reset clears all control state; no clearing pass is needed.
// A stalled result holds the sequencer at its next result, and the next input
// transfer is taken while a result still waits.
// ----------------------------------------------------------------------------
module multilevel_feedback_dispatcher #(
	parameter int MAX_CPUS     = mfd_pkg::MAX_CPUS_DEF,
	parameter int QUEUE_DEPTH  = mfd_pkg::QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = mfd_pkg::TASK_ID_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire logic [7:0] task_id,
	input  wire logic [3:0] requested_priority,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [1:0]      status,
	output logic [2:0]      slot,
	output logic [7:0]      task_id_res,
	output logic [2:0]      level,
	output logic            last
);

	// command from the sequencer, status back from the datapath
	mfd_pkg::cmd_t cmd;
	mfd_pkg::st_t  st;

	// sequencer: one command per cycle while no stalled result holds it, takes input transfers only when idle
	mfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.st       (st),
		.cmd      (cmd)
	);

	// level FIFOs, pending buffer, slot table, registers and result register
	mfd_datapath #(
		.MAX_CPUS     (MAX_CPUS),
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.TASK_ID_BITS (TASK_ID_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.task_id            (task_id),
		.requested_priority (requested_priority),
		.cmd                (cmd),
		.st                 (st),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.kind               (kind),
		.status             (status),
		.slot               (slot),
		.task_id_res        (task_id_res),
		.level              (level),
		.last               (last)
	);

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the four-level feedback queue dispatcher
// Drives submit, finish, tick and unused-code transfers and register writes with
// random gaps and stalls, predicts all results in a local scheduler model and
// compares each result transfer field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH = mfd_pkg::QUEUE_DEPTH_DEF;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [1:0] kind;
		logic [1:0] status;
		logic [2:0] slot;
		logic [7:0] id;
		logic [2:0] level;
		logic       last;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = '0;
	logic [7:0] task_id = '0;
	logic [3:0] requested_priority = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind, status;
	logic [2:0] slot, level;
	logic [7:0] task_id_res;
	logic last;

	multilevel_feedback_dispatcher dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: the scheduler's queues, pending buffer and slots.
	logic [3:0] m_cpus;
	logic [7:0] m_period;
	logic [7:0] lvq[4][$];
	logic [7:0] pend_id[$];
	logic [2:0] pend_lv[$];
	logic run_valid[8], run_done[8];
	logic [7:0] run_id[8];
	logic [2:0] run_lv[8];
	int live_tasks;
	logic [7:0] tick_count;

	sched_res_t expected_q[$];
	int errors = 0;
	int sent = 0;
	int results_seen = 0;
	int dispatches_seen = 0;
	longint cycles = 0;
	bit stall_quiet = 1'b0;

	function automatic sched_res_t mk(logic [1:0] k, logic [1:0] s, logic [2:0] sl,
			logic [7:0] id, logic [2:0] lv);
		sched_res_t r;
		r.kind = k; r.status = s; r.slot = sl; r.id = id; r.level = lv; r.last = 1'b0;
		return r;
	endfunction

	task automatic predictor_reset();
		m_cpus = mfd_pkg::CPU_COUNT_RESET;
		m_period = mfd_pkg::BOOST_PERIOD_RESET;
		for (int l = 0; l < 4; l++) lvq[l].delete();
		pend_id.delete();
		pend_lv.delete();
		for (int i = 0; i < 8; i++) begin
			run_valid[i] = 0; run_done[i] = 0; run_id[i] = 0; run_lv[i] = 0;
		end
		live_tasks = 0;
		tick_count = 0;
	endtask

	// Work out the results of one accepted transfer and queue them.
	task automatic predict_schedule(logic [1:0] f, logic [7:0] id, logic [3:0] pr);
		sched_res_t r;
		logic [2:0] p;
		logic [1:0] st;
		bit boost;
		int lim, n, total;
		if (f == mfd_pkg::FUNC_SUBMIT) begin
			p = (pr >= 1 && pr <= 4) ? pr[2:0] : 3'd1;
			if (live_tasks >= DEPTH || pend_id.size() >= DEPTH) begin
				r = mk(mfd_pkg::KIND_ACK, mfd_pkg::STAT_FULL, 3'd0, id, p);
			end else begin
				pend_id.push_back(id);
				pend_lv.push_back(p);
				live_tasks++;
				r = mk(mfd_pkg::KIND_ACK, mfd_pkg::STAT_OK, 3'd0, id, p);
			end
			r.last = 1'b1;
			expected_q.push_back(r);
		end else if (f == mfd_pkg::FUNC_FINISH) begin
			st = mfd_pkg::STAT_NOT_RUN;
			for (int i = 0; i < 8; i++) begin
				if (run_valid[i] && !run_done[i] && run_id[i] == id) begin
					run_done[i] = 1;
					if (live_tasks > 0) live_tasks--;
					st = mfd_pkg::STAT_OK;
					break;
				end
			end
			r = mk(mfd_pkg::KIND_ACK, st, 3'd0, id, 3'd0);
			r.last = 1'b1;
			expected_q.push_back(r);
		end else if (f == mfd_pkg::FUNC_TICK) begin
			tick_count++;
			boost = (tick_count == m_period);
			if (boost) begin
				// gather levels 4, 3, 2 into level 1, each in FIFO order
				for (int l = 3; l >= 1; l--)
					while (lvq[l].size() > 0) lvq[0].push_back(lvq[l].pop_front());
				tick_count = 0;
			end
			foreach (pend_id[i]) lvq[pend_lv[i] - 1].push_back(pend_id[i]);
			pend_id.delete();
			pend_lv.delete();
			for (int i = 0; i < 8; i++) begin
				if (run_valid[i] && !run_done[i])
					lvq[boost ? 0 : (run_lv[i] >= 4 ? 3 : run_lv[i])].push_back(run_id[i]);
				run_valid[i] = 0;
				run_done[i] = 0;
			end
			lim = (m_cpus == 0) ? 1 : (m_cpus > 8 ? 8 : m_cpus);
			total = 0;
			for (int l = 0; l < 4; l++) total += lvq[l].size();
			if (total == 0) begin
				r = mk(mfd_pkg::KIND_IDLE, mfd_pkg::STAT_OK, 3'd0, 8'd0, 3'd0);
				r.last = 1'b1;
				expected_q.push_back(r);
			end else begin
				n = 0;
				for (int l = 0; l < 4 && n < lim; l++) begin
					while (n < lim && lvq[l].size() > 0) begin
						run_valid[n] = 1;
						run_done[n] = 0;
						run_id[n] = lvq[l].pop_front();
						run_lv[n] = 3'(l + 1);
						r = mk(mfd_pkg::KIND_DISP, mfd_pkg::STAT_OK, 3'(n), run_id[n],
							3'(l + 1));
						r.last = (n == lim - 1) || (total == n + 1);
						expected_q.push_back(r);
						n++;
					end
				end
			end
		end
	endtask

	function automatic int gap_len();
		int u = $urandom_range(0, 99);
		if (u < 55) return 0;
		if (u < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Send one transfer on the input channel and record its prediction.
	task automatic send_item(logic [1:0] f, logic [7:0] id, logic [3:0] pr);
		int g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		task_id <= id;
		requested_priority <= pr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_schedule(f, id, pr);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() > 0) @(posedge clk);
		// let the sequencer finish any transfer with no result
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mfd_pkg::REG_CPU_COUNT) m_cpus = val[3:0];
		else m_period = val;
		@(posedge clk);
	endtask

	// Result checker: compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		sched_res_t e;
		cycles++;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (kind == mfd_pkg::KIND_DISP) dispatches_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result kind=%0d id=%0d", $time, kind, task_id_res);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (kind !== e.kind || status !== e.status || slot !== e.slot ||
						task_id_res !== e.id || level !== e.level || last !== e.last) begin
					$display("%0t: expected k%0d s%0d sl%0d id%0d lv%0d l%0d, got k%0d s%0d sl%0d id%0d lv%0d l%0d",
						$time, e.kind, e.status, e.slot, e.id, e.level, e.last,
						kind, status, slot, task_id_res, level, last);
					errors++;
				end
			end
		end
		if (cycles > 400000) begin
			$display("multilevel_feedback_dispatcher: mismatch");
			$finish;
		end
	end

	// Receiver stalls: drawn at random each cycle, quiet stretches too.
	always @(posedge clk) begin
		int u;
		u = $urandom_range(0, 99);
		if (stall_quiet) out_stall <= 1'b0;
		else if (u < 60) out_stall <= 1'b0;
		else if (u < 97) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	task automatic test_directed();
		// priority extremes, out-of-range priority, id extremes
		send_item(mfd_pkg::FUNC_TICK, 8'h00, 4'h0);
		send_item(mfd_pkg::FUNC_SUBMIT, 8'h00, 4'h0);
		send_item(mfd_pkg::FUNC_SUBMIT, 8'hFF, 4'hF);
		send_item(mfd_pkg::FUNC_SUBMIT, 8'h55, 4'd4);
		send_item(mfd_pkg::FUNC_SUBMIT, 8'hAA, 4'd3);
		send_item(mfd_pkg::FUNC_SUBMIT, 8'h0F, 4'd2);
		send_item(mfd_pkg::FUNC_FINISH, 8'h12, 4'd0);
		send_item(FUNC_UNUSED, 8'hF0, 4'hA);
		send_item(mfd_pkg::FUNC_TICK, 8'hFF, 4'hF);
		send_item(mfd_pkg::FUNC_FINISH, 8'h00, 4'd0);
		send_item(mfd_pkg::FUNC_FINISH, 8'h00, 4'd0);
		send_item(mfd_pkg::FUNC_TICK, 8'h00, 4'h0);
		send_item(mfd_pkg::FUNC_TICK, 8'h00, 4'h0);
		send_item(mfd_pkg::FUNC_TICK, 8'h00, 4'h0);
		drain();
	endtask

	task automatic test_store_full();
		// fill the store past its bound, then dispatch on all slots
		write_reg(mfd_pkg::REG_CPU_COUNT, 8'd8);
		for (int i = 0; i < 70; i++)
			send_item(mfd_pkg::FUNC_SUBMIT, i[7:0], 4'($urandom_range(0, 15)));
		for (int i = 0; i < 6; i++) send_item(mfd_pkg::FUNC_TICK, 8'h00, 4'h0);
		drain();
	endtask

	// Random traffic: submits, finishes mostly of running tasks, ticks, plus noise.
	task automatic test_random(int count);
		logic [1:0] f;
		logic [7:0] id;
		int u;
		for (int k = 0; k < count; k++) begin
			u = $urandom_range(0, 99);
			stall_quiet = (k % 80) < 10;
			id = 8'($urandom_range(0, 255));
			if (u < 40) f = mfd_pkg::FUNC_SUBMIT;
			else if (u < 70) begin
				f = mfd_pkg::FUNC_FINISH;
				if ($urandom_range(0, 3) != 0) id = run_id[$urandom_range(0, 7)];
			end else if (u < 97) f = mfd_pkg::FUNC_TICK;
			else f = FUNC_UNUSED;
			send_item(f, id, 4'($urandom_range(0, 15)));
		end
		stall_quiet = 1'b0;
		drain();
	endtask

	task automatic test_config_sweep();
		write_reg(mfd_pkg::REG_CPU_COUNT, 8'd0);
		write_reg(mfd_pkg::REG_BOOST_PERIOD, 8'd1);
		test_random(60);
		write_reg(mfd_pkg::REG_CPU_COUNT, 8'd15);
		write_reg(mfd_pkg::REG_BOOST_PERIOD, 8'd255);
		test_random(60);
		write_reg(mfd_pkg::REG_CPU_COUNT, 8'd3);
		write_reg(mfd_pkg::REG_BOOST_PERIOD, 8'd0);
		test_random(60);
		write_reg(mfd_pkg::REG_CPU_COUNT, 8'd1);
		write_reg(mfd_pkg::REG_BOOST_PERIOD, 8'd2);
		test_random(50);
		write_reg(mfd_pkg::REG_CPU_COUNT, 8'($urandom_range(1, 8)));
		write_reg(mfd_pkg::REG_BOOST_PERIOD, 8'($urandom_range(1, 6)));
		test_random(40);
	endtask

	initial begin
		predictor_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_store_full();
		test_config_sweep();
		$display("Sent %0d transfers, checked %0d results (%0d dispatches).",
			sent, results_seen, dispatches_seen);
		$display("Covered store full, unknown finish, idle ticks, boosts and slot extremes.");
		if (errors == 0 && expected_q.size() == 0)
			$display("multilevel_feedback_dispatcher: match");
		else
			$display("multilevel_feedback_dispatcher: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
sv/mfd_pkg.sv
sv/mfd_ctrl.sv
sv/mfd_datapath.sv
sv/multilevel_feedback_dispatcher.sv
sim/tb.sv
